>>> rtl/quadratic_probe_hash_table_defines.svh
// assertion macros for the quadratic probe hash table
`ifndef QUADRATIC_PROBE_HASH_TABLE_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define QPHT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qpht assertion failed");
`define QPHT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qpht assertion failed");
`else
`define QPHT_ASSERT_IMP(label, clk, rst, ante, cons)
`define QPHT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/qpht_pkg.sv
// shared constants, codes and control types of the quadratic probe hash table
package qpht_pkg;

   localparam int TABLE_SIZE = 16;
   localparam int SLOT_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int KEY_W      = 31;
   localparam int VALUE_W    = 64;
   localparam int STATUS_W   = 2;
   localparam int RSP_SLOT_W = 4;
   localparam int HCNT_W     = $clog2(KEY_W + 1);
   localparam bit TABLE_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STAT_INSERTED = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_FOUND    = 2'd2,
      STAT_MISSING  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_PROBE
   } state_type;

   typedef struct packed {
      logic       clear_en;
      logic       capture;
      logic       hash_en;
      logic       load_home;
      logic       advance;
      logic       write_en;
      logic       result_load;
      status_type result_status;
      logic       result_hit;
      logic       result_value;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic hash_done;
      logic is_search;
      logic occ;
      logic key_match;
      logic last_attempt;
   } sts_type;

endpackage

>>> rtl/quadratic_probe_hash_table.sv
// a request takes 1 to TABLE_SIZE probes between its acceptance and its response
// (a table size that is not a power of two adds a bit-serial key remainder before probing)
// a new request is accepted only after the previous one has loaded its result; there is a single
// probe per cycle through the registered read of the slot rams, held while a response stalls
// reset: synchronous; a pass over all TABLE_SIZE slots then clears the occupancy ram, req_stall high
module quadratic_probe_hash_table (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [qpht_pkg::KEY_W-1:0]       req_key,
   input  logic [qpht_pkg::VALUE_W-1:0]     req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [qpht_pkg::STATUS_W-1:0]    rsp_status,
   output logic [qpht_pkg::RSP_SLOT_W-1:0]  rsp_slot,
   output logic [qpht_pkg::VALUE_W-1:0]     rsp_found_value
);

   qpht_pkg::cmd_type cmd;
   qpht_pkg::sts_type sts;

   qpht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   qpht_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_type        (req_type),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_found_value (rsp_found_value)
   );

endmodule

>>> rtl/qpht_ram.sv
// generic single write port ram with registered read
module qpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/qpht_datapath.sv
// request registers, hashing, probe sequence, table rams and result registers
module qpht_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  qpht_pkg::cmd_type                cmd,
   output qpht_pkg::sts_type                sts,
   input  logic                             req_type,
   input  logic [qpht_pkg::KEY_W-1:0]       req_key,
   input  logic [qpht_pkg::VALUE_W-1:0]     req_value,
   output logic [qpht_pkg::STATUS_W-1:0]    rsp_status,
   output logic [qpht_pkg::RSP_SLOT_W-1:0]  rsp_slot,
   output logic [qpht_pkg::VALUE_W-1:0]     rsp_found_value
);

   localparam int SW = qpht_pkg::SLOT_W;
   localparam int KW = qpht_pkg::KEY_W;
   localparam int VW = qpht_pkg::VALUE_W;
   localparam logic [SW+1:0] SIZE_X1 = (SW + 2)'(qpht_pkg::TABLE_SIZE);
   localparam logic [SW+1:0] SIZE_X2 = (SW + 2)'(2 * qpht_pkg::TABLE_SIZE);
   localparam logic [SW-1:0] LAST_IDX = SW'(qpht_pkg::TABLE_SIZE - 1);

   logic                req_search_ff;
   logic [KW-1:0]       key_ff;
   logic [VW-1:0]       value_ff;
   logic [SW-1:0]       slot_ff, slot_in;
   logic [SW-1:0]       attempt_ff, attempt_in;
   logic [SW-1:0]       clr_ff;
   logic [SW-1:0]       home;
   logic                hash_done;
   logic [SW+1:0]       probe_sum;
   logic [SW+1:0]       probe_wrap;
   logic [SW-1:0]       slot_next;
   logic [0:0]          occ_rd;
   logic [KW+VW-1:0]    ent_rd;
   qpht_pkg::status_type        rsp_status_ff;
   logic [qpht_pkg::RSP_SLOT_W-1:0] rsp_slot_ff;
   logic [VW-1:0]       rsp_value_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_search_ff <= (req_type == qpht_pkg::REQ_SEARCH);
         key_ff        <= req_key;
         value_ff      <= req_value;
      end
   end

   // home slot: mask for a power of two, else restoring remainder one key bit a cycle
   generate
      if (qpht_pkg::TABLE_POW2) begin : g_mask
         assign home      = key_ff[SW-1:0];
         assign hash_done = 1'b1;
      end else begin : g_rem
         logic [SW-1:0]                 rem_ff;
         logic [qpht_pkg::HCNT_W-1:0]   hcnt_ff;
         logic [KW-1:0]                 key_sh_ff;
         logic [SW:0]                   rem_sh;
         logic [SW:0]                   rem_sub;

         assign rem_sh  = {rem_ff, key_sh_ff[KW-1]};
         assign rem_sub = (rem_sh >= SIZE_X1[SW:0]) ? (rem_sh - SIZE_X1[SW:0]) : rem_sh;

         always_ff @(posedge clock) begin
            if (reset) begin
               hcnt_ff <= '0;
            end else if (cmd.capture) begin
               hcnt_ff <= '0;
            end else if (cmd.hash_en) begin
               hcnt_ff <= hcnt_ff + 1'b1;
            end
         end

         always_ff @(posedge clock) begin
            if (cmd.capture) begin
               rem_ff    <= '0;
               key_sh_ff <= req_key;
            end else if (cmd.hash_en) begin
               rem_ff    <= rem_sub[SW-1:0];
               key_sh_ff <= {key_sh_ff[KW-2:0], 1'b0};
            end
         end

         assign home      = rem_ff;
         assign hash_done = (hcnt_ff == qpht_pkg::HCNT_W'(KW));
      end
   endgenerate

   // (a+1)^2 - a^2 = 2a+1, so each attempt adds an odd step below twice the size
   assign probe_sum  = {2'b00, slot_ff} + (SW + 2)'({attempt_ff, 1'b1});
   always_comb begin
      if (probe_sum >= SIZE_X2) begin
         probe_wrap = probe_sum - SIZE_X2;
      end else if (probe_sum >= SIZE_X1) begin
         probe_wrap = probe_sum - SIZE_X1;
      end else begin
         probe_wrap = probe_sum;
      end
   end
   assign slot_next = probe_wrap[SW-1:0];

   always_comb begin
      slot_in    = slot_ff;
      attempt_in = attempt_ff;
      if (cmd.load_home) begin
         slot_in    = home;
         attempt_in = '0;
      end else if (cmd.advance) begin
         slot_in    = slot_next;
         attempt_in = attempt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= '0;
         attempt_ff <= '0;
      end else begin
         slot_ff    <= slot_in;
         attempt_ff <= attempt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_en) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // rams read at the slot being loaded, so data matches slot_ff in the cycle after
   qpht_ram #(
      .WIDTH (1),
      .DEPTH (qpht_pkg::TABLE_SIZE)
   ) u_occ_ram (
      .clock   (clock),
      .wr_en   (cmd.clear_en | cmd.write_en),
      .wr_addr (cmd.clear_en ? clr_ff : slot_ff),
      .wr_data (~cmd.clear_en),
      .rd_addr (slot_in),
      .rd_data (occ_rd)
   );

   qpht_ram #(
      .WIDTH (KW + VW),
      .DEPTH (qpht_pkg::TABLE_SIZE)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.write_en),
      .wr_addr (slot_ff),
      .wr_data ({key_ff, value_ff}),
      .rd_addr (slot_in),
      .rd_data (ent_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_status_ff <= cmd.result_status;
         rsp_slot_ff   <= cmd.result_hit ? qpht_pkg::RSP_SLOT_W'(slot_ff) : '0;
         rsp_value_ff  <= cmd.result_value ? ent_rd[VW-1:0] : '0;
      end
   end

   assign sts.clear_last   = (clr_ff == LAST_IDX);
   assign sts.hash_done    = hash_done;
   assign sts.is_search    = req_search_ff;
   assign sts.occ          = occ_rd[0];
   assign sts.key_match    = (ent_rd[VW +: KW] == key_ff);
   assign sts.last_attempt = (attempt_ff == LAST_IDX);

   assign rsp_status      = rsp_status_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_found_value = rsp_value_ff;

endmodule

>>> rtl/qpht_ctrl.sv
// controller state machine and result valid register
`include "quadratic_probe_hash_table_defines.svh"

module qpht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  qpht_pkg::sts_type sts,
   output qpht_pkg::cmd_type cmd
);

   qpht_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;
   logic                probe_done;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         qpht_pkg::ST_CLEAR: begin
            if (sts.clear_last) state_in = qpht_pkg::ST_IDLE;
         end
         qpht_pkg::ST_IDLE: begin
            if (req_valid) state_in = qpht_pkg::ST_HASH;
         end
         qpht_pkg::ST_HASH: begin
            if (sts.hash_done) state_in = qpht_pkg::ST_PROBE;
         end
         qpht_pkg::ST_PROBE: begin
            if (cmd.result_load) state_in = qpht_pkg::ST_IDLE;
         end
         default: begin
            state_in = qpht_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      probe_done = 1'b0;
      req_stall  = (state_ff != qpht_pkg::ST_IDLE);
      case (state_ff)
         qpht_pkg::ST_CLEAR: begin
            cmd.clear_en = 1'b1;
         end
         qpht_pkg::ST_IDLE: begin
            cmd.capture = req_valid;
         end
         qpht_pkg::ST_HASH: begin
            if (sts.hash_done) begin
               cmd.load_home = 1'b1;
            end else begin
               cmd.hash_en = 1'b1;
            end
         end
         qpht_pkg::ST_PROBE: begin
            if (sts.is_search) begin
               if (!sts.occ) begin
                  probe_done        = 1'b1;
                  cmd.result_status = qpht_pkg::STAT_MISSING;
               end else if (sts.key_match) begin
                  probe_done        = 1'b1;
                  cmd.result_status = qpht_pkg::STAT_FOUND;
                  cmd.result_hit    = 1'b1;
                  cmd.result_value  = 1'b1;
               end else if (sts.last_attempt) begin
                  probe_done        = 1'b1;
                  cmd.result_status = qpht_pkg::STAT_MISSING;
               end
            end else begin
               if (!sts.occ) begin
                  probe_done        = 1'b1;
                  cmd.result_status = qpht_pkg::STAT_INSERTED;
                  cmd.result_hit    = 1'b1;
               end else if (sts.last_attempt) begin
                  probe_done        = 1'b1;
                  cmd.result_status = qpht_pkg::STAT_FULL;
               end
            end
            // hold on the current slot while the previous response is still stalled
            if (probe_done) begin
               cmd.result_load = out_free;
               cmd.write_en    = out_free & ~sts.is_search & ~sts.occ;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.result_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qpht_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `QPHT_ASSERT_NXT(a_accept_to_hash, clock, reset, req_valid && !req_stall, state_ff == qpht_pkg::ST_HASH)
   `QPHT_ASSERT_NXT(a_result_to_idle, clock, reset, cmd.result_load, (state_ff == qpht_pkg::ST_IDLE) && rsp_valid_ff)
   `QPHT_ASSERT_IMP(a_write_free_slot, clock, reset, cmd.write_en, !sts.occ && !sts.is_search && (state_ff == qpht_pkg::ST_PROBE))
   `QPHT_ASSERT_IMP(a_clear_no_result, clock, reset, cmd.clear_en, !rsp_valid_ff)

endmodule
